// ----- rtl/core/sql_text_tokenizer_unit_macros.svh -----
// Assertion macros for the checker file of the SQL text tokenizer.
// Needs nothing but a clock and an active-low reset in the calling scope.
`ifndef SQL_TEXT_TOKENIZER_UNIT_MACROS_SVH
`define SQL_TEXT_TOKENIZER_UNIT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define STT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Checked on every rising edge, reset cycles included.
`define STT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/stt_pkg.sv -----
// Shared types, codes and character helpers of the SQL text tokenizer.
// No dependencies; used by the top level and by its checker.
package stt_pkg;

    localparam int DEF_MAX_TOKEN_LEN = 32;
    localparam int DEF_BLOB_LEN_BITS = 32;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } stt_in_t;

    typedef struct packed {
        logic [7:0] token_char;
        logic       char_valid;
        logic       token_last;
        logic [1:0] token_type;
        logic [1:0] fault;
        logic       run_last;
    } stt_out_t;

    localparam logic [1:0] TYPE_PLAIN = 2'd0;
    localparam logic [1:0] TYPE_NAME  = 2'd1;
    localparam logic [1:0] TYPE_TEXT  = 2'd2;
    localparam logic [1:0] TYPE_BLOB  = 2'd3;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_BAD_LEN = 2'd1;
    localparam logic [1:0] FAULT_NO_HASH = 2'd2;
    localparam logic [1:0] FAULT_TRUNC   = 2'd3;

    localparam logic [1:0] QK_DOUBLE = 2'd0;
    localparam logic [1:0] QK_SINGLE = 2'd1;
    localparam logic [1:0] QK_TICK   = 2'd2;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_BSL     = 8'h5C;
    localparam logic [7:0] CH_TICK    = 8'h60;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) || (b == CH_CR);
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b == 8'h3B) || (b == 8'h3D) || (b == 8'h2B) || (b == CH_STAR) ||
               (b == 8'h21) || (b == 8'h2C) || (b == 8'h28) || (b == 8'h29);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ? (b + 8'd32) : b;
    endfunction

    // An out-of-range quote kind behaves as a double quote.
    function automatic logic [7:0] quote_char(input logic [1:0] qk);
        logic [7:0] c;
        case (qk)
            QK_SINGLE: c = CH_SQUOTE;
            QK_TICK:   c = CH_TICK;
            default:   c = CH_DQUOTE;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] quote_type(input logic [1:0] qk);
        logic [1:0] t;
        case (qk)
            QK_SINGLE: t = TYPE_PLAIN;
            QK_TICK:   t = TYPE_NAME;
            default:   t = TYPE_TEXT;
        endcase
        return t;
    endfunction

    function automatic stt_out_t make_item(input logic [7:0] ch, input logic valid,
                                           input logic last, input logic [1:0] ttype,
                                           input logic [1:0] flt);
        stt_out_t r;
        r.token_char = ch;
        r.char_valid = valid;
        r.token_last = last;
        r.token_type = ttype;
        r.fault      = flt;
        r.run_last   = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/core/stt_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the token characters of the tokenizer.
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/sql_text_tokenizer_unit.sv -----
// Streaming SQL tokenizer: one query byte in, token characters out.
// Input s_* and result m_* channels are valid/ready; an item moves when both are high.
// Each input item carries a text byte and an end_of_text flag; end_of_text flushes
// the pending token and returns the lexer to plain mode. Each result item is one
// token character with last-of-token, token type and fault; run_last marks the last
// result caused by one input item.
// A byte that only extends a token or changes lexer mode passes through S_END and
// back to S_IDLE. Every emitted token character takes a token RAM read, then a load
// into the result path, and each blob length digit takes a read and a check; both walk
// the token RAM one entry at a time. Results pass through a one-entry holding stage
// and an output register before they leave the block.
// A stalled receiver holds the output register; the block keeps working until the
// holding stage is also full and then waits. s_ready is high only between items.
// Reset (synchronous, active low) empties both result stages, clears the token
// length, blob count and quote kind and puts the lexer into plain mode. The token
// RAM is not cleared: only entries below the current length are ever read.
// Depends on stt_pkg and stt_ram.
module sql_text_tokenizer_unit #(
    parameter int MAX_TOKEN_LEN = stt_pkg::DEF_MAX_TOKEN_LEN,
    parameter int BLOB_LEN_BITS = stt_pkg::DEF_BLOB_LEN_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  stt_pkg::stt_in_t   s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output stt_pkg::stt_out_t  m_item
);
    import stt_pkg::*;

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
    localparam int AW = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
    localparam int BW = BLOB_LEN_BITS;
    localparam int PW = BLOB_LEN_BITS + 4;

    // Lexer modes.
    localparam logic [3:0] M_PLAIN  = 4'd0;
    localparam logic [3:0] M_QUOTE  = 4'd1;
    localparam logic [3:0] M_QESC   = 4'd2;
    localparam logic [3:0] M_QCLOSE = 4'd3;
    localparam logic [3:0] M_DASH   = 4'd4;
    localparam logic [3:0] M_SLASH  = 4'd5;
    localparam logic [3:0] M_LINE   = 4'd6;
    localparam logic [3:0] M_BLOCK  = 4'd7;
    localparam logic [3:0] M_BSTAR  = 4'd8;
    localparam logic [3:0] M_BLOB   = 4'd9;
    localparam logic [3:0] M_BHASH  = 4'd10;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LEX   = 4'd1;
    localparam logic [3:0] S_LEX2  = 4'd2;
    localparam logic [3:0] S_ERD   = 4'd3;
    localparam logic [3:0] S_EOUT  = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PCHK  = 4'd6;
    localparam logic [3:0] S_PFAIL = 4'd7;
    localparam logic [3:0] S_END   = 4'd8;
    localparam logic [3:0] S_ENDX  = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [3:0]    mode_reg, mode_next;
    logic [1:0]    qk_reg, qk_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [BW-1:0] rem_reg, rem_next;
    logic [7:0]    byte_reg, byte_next;
    logic          end_reg, end_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [BW-1:0] val_reg, val_next;
    logic [1:0]    em_type_reg, em_type_next;
    logic [1:0]    em_fault_reg, em_fault_next;
    logic [3:0]    cont_reg, cont_next;
    logic          pend_valid_reg, pend_valid_next;
    stt_out_t      pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    stt_out_t      out_reg, out_next;

    logic          s_accept;
    logic          out_free;
    logic          push_ok;
    logic          push_req;
    stt_out_t      push_item;
    logic          app_req;
    logic [7:0]    app_val;
    logic          clr_req;
    logic          em_req;
    logic [1:0]    em_type;
    logic [1:0]    em_fault;
    logic [3:0]    em_cont;
    logic          lex_req;
    logic          fin_req;
    logic          fin_go;
    logic [7:0]    lex_byte;
    logic [7:0]    in_byte;
    logic          emit_last;
    logic [PW-1:0] prod;
    logic          digit_ok;
    logic [BW-1:0] rem_dec;

    logic          ram_we;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    stt_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TOKEN_LEN)
    ) u_token_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;
    assign push_ok   = !pend_valid_reg || out_free;
    assign in_byte   = s_item.text_byte;
    assign lex_byte  = (state_reg == S_IDLE) ? in_byte : byte_reg;
    assign emit_last = (LW'(idx_reg + LW'(1)) == len_reg);
    assign rem_dec   = rem_reg - BW'(1);

    // Decimal accumulate: value * 10 + digit, with room to detect overflow.
    assign prod = (PW'(val_reg) << 3) + (PW'(val_reg) << 1) + PW'(ram_rd_data[3:0]);
    assign digit_ok = (ram_rd_data >= CH_ZERO) && (ram_rd_data <= CH_NINE) &&
                      (prod[PW-1:BW] == 4'd0);

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        qk_next       = qk_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        rem_next      = rem_reg;
        byte_next     = byte_reg;
        end_next      = end_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        em_type_next  = em_type_reg;
        em_fault_next = em_fault_reg;
        cont_next     = cont_reg;

        push_req  = 1'b0;
        push_item = make_item(8'd0, 1'b0, 1'b0, TYPE_PLAIN, FAULT_NONE);
        app_req   = 1'b0;
        app_val   = 8'd0;
        clr_req   = 1'b0;
        em_req    = 1'b0;
        em_type   = TYPE_PLAIN;
        em_fault  = FAULT_NONE;
        em_cont   = S_END;
        lex_req   = 1'b0;
        fin_req   = 1'b0;

        ram_we      = 1'b0;
        ram_wr_addr = len_reg[AW-1:0];
        ram_wr_data = 8'd0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    byte_next  = in_byte;
                    end_next   = s_item.end_of_text;
                    state_next = S_END;
                    unique case (mode_reg)
                        M_QUOTE: begin
                            if (in_byte == CH_BSL) begin
                                mode_next = M_QESC;
                            end else if (in_byte == quote_char(qk_reg)) begin
                                mode_next = M_QCLOSE;
                            end else begin
                                app_req = 1'b1;
                                app_val = in_byte;
                            end
                        end
                        M_QESC: begin
                            app_req   = 1'b1;
                            app_val   = in_byte;
                            mode_next = M_QUOTE;
                        end
                        M_QCLOSE: begin
                            if (in_byte == quote_char(qk_reg)) begin
                                app_req   = 1'b1;
                                app_val   = in_byte;
                                mode_next = M_QUOTE;
                            end else begin
                                em_req  = 1'b1;
                                em_type = quote_type(qk_reg);
                                em_cont = S_LEX;
                            end
                        end
                        M_DASH: begin
                            if (in_byte == CH_DASH) begin
                                mode_next = M_LINE;
                            end else begin
                                push_req   = 1'b1;
                                push_item  = make_item(CH_DASH, 1'b1, 1'b1, TYPE_PLAIN,
                                                       FAULT_NONE);
                                state_next = S_LEX;
                            end
                        end
                        M_SLASH: begin
                            if (in_byte == CH_STAR) begin
                                mode_next = M_BLOCK;
                            end else begin
                                push_req   = 1'b1;
                                push_item  = make_item(CH_SLASH, 1'b1, 1'b1, TYPE_PLAIN,
                                                       FAULT_NONE);
                                state_next = S_LEX;
                            end
                        end
                        M_LINE: begin
                            if (in_byte == CH_NL) begin
                                mode_next = M_PLAIN;
                            end
                        end
                        M_BLOCK: begin
                            if (in_byte == CH_STAR) begin
                                mode_next = M_BSTAR;
                            end
                        end
                        M_BSTAR: begin
                            if (in_byte == CH_SLASH) begin
                                mode_next = M_PLAIN;
                            end else if (in_byte != CH_STAR) begin
                                mode_next = M_BLOCK;
                            end
                        end
                        M_BLOB: begin
                            app_req  = 1'b1;
                            app_val  = in_byte;
                            rem_next = rem_dec;
                            if (rem_dec == '0) begin
                                mode_next = M_BHASH;
                            end
                        end
                        M_BHASH: begin
                            em_req  = 1'b1;
                            em_type = TYPE_BLOB;
                            if (in_byte == CH_HASH) begin
                                mode_next = M_PLAIN;
                                em_cont   = S_END;
                            end else begin
                                em_fault = FAULT_NO_HASH;
                                em_cont  = S_LEX;
                            end
                        end
                        default: begin
                            lex_req = 1'b1;
                        end
                    endcase
                end
            end
            S_LEX: begin
                lex_req = 1'b1;
            end
            S_LEX2: begin
                if (push_ok) begin
                    push_req   = 1'b1;
                    push_item  = make_item(byte_reg, 1'b1, 1'b1, TYPE_PLAIN, FAULT_NONE);
                    state_next = S_END;
                end
            end
            S_ERD: begin
                if (len_reg == '0) begin
                    // An empty token still closes with one result.
                    if (push_ok) begin
                        push_req   = 1'b1;
                        push_item  = make_item(8'd0, 1'b0, 1'b1, em_type_reg, em_fault_reg);
                        clr_req    = 1'b1;
                        state_next = cont_reg;
                    end
                end else begin
                    ram_rd_en  = 1'b1;
                    state_next = S_EOUT;
                end
            end
            S_EOUT: begin
                if (push_ok) begin
                    push_req  = 1'b1;
                    push_item = make_item(ram_rd_data, 1'b1, emit_last, em_type_reg,
                                          em_fault_reg);
                    if (emit_last) begin
                        clr_req    = 1'b1;
                        state_next = cont_reg;
                    end else begin
                        idx_next   = LW'(idx_reg + LW'(1));
                        state_next = S_ERD;
                    end
                end
            end
            S_PRD: begin
                if ((len_reg == '0) || ovf_reg) begin
                    state_next = S_PFAIL;
                end else if (idx_reg == len_reg) begin
                    rem_next   = val_reg;
                    mode_next  = (val_reg != '0) ? M_BLOB : M_BHASH;
                    clr_req    = 1'b1;
                    state_next = S_END;
                end else begin
                    ram_rd_en  = 1'b1;
                    state_next = S_PCHK;
                end
            end
            S_PCHK: begin
                if (digit_ok) begin
                    val_next   = prod[BW-1:0];
                    idx_next   = LW'(idx_reg + LW'(1));
                    state_next = S_PRD;
                end else begin
                    state_next = S_PFAIL;
                end
            end
            S_PFAIL: begin
                if (push_ok) begin
                    push_req   = 1'b1;
                    push_item  = make_item(8'd0, 1'b0, 1'b0, TYPE_PLAIN, FAULT_BAD_LEN);
                    clr_req    = 1'b1;
                    mode_next  = M_PLAIN;
                    state_next = S_END;
                end
            end
            S_END: begin
                if (end_reg) begin
                    state_next = S_ENDX;
                    unique case (mode_reg)
                        M_QCLOSE: begin
                            em_req  = 1'b1;
                            em_type = quote_type(qk_reg);
                            em_cont = S_ENDX;
                        end
                        M_PLAIN, M_QUOTE, M_QESC: begin
                            if (len_reg != '0) begin
                                em_req  = 1'b1;
                                em_cont = S_ENDX;
                            end
                        end
                        M_DASH, M_SLASH: begin
                            if (push_ok) begin
                                push_req  = 1'b1;
                                push_item = make_item((mode_reg == M_DASH) ? CH_DASH :
                                                      CH_SLASH, 1'b1, 1'b1, TYPE_PLAIN,
                                                      FAULT_NONE);
                            end else begin
                                state_next = S_END;
                            end
                        end
                        M_BLOB, M_BHASH: begin
                            em_req   = 1'b1;
                            em_type  = TYPE_BLOB;
                            em_fault = FAULT_NO_HASH;
                            em_cont  = S_ENDX;
                        end
                        default: begin
                            state_next = S_ENDX;
                        end
                    endcase
                end else begin
                    fin_req = 1'b1;
                end
            end
            S_ENDX: begin
                mode_next = M_PLAIN;
                clr_req   = 1'b1;
                rem_next  = '0;
                fin_req   = 1'b1;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Plain-text lexing of one byte; waits while a result cannot be taken.
        if (lex_req && push_ok) begin
            mode_next  = M_PLAIN;
            state_next = S_END;
            if (lex_byte == CH_DQUOTE) begin
                qk_next   = QK_DOUBLE;
                mode_next = M_QUOTE;
            end else if (lex_byte == CH_SQUOTE) begin
                qk_next   = QK_SINGLE;
                mode_next = M_QUOTE;
            end else if (lex_byte == CH_TICK) begin
                qk_next   = QK_TICK;
                mode_next = M_QUOTE;
            end else if (is_space(lex_byte) || (lex_byte == CH_DASH) ||
                         (lex_byte == CH_SLASH)) begin
                if (lex_byte == CH_DASH) begin
                    mode_next = M_DASH;
                end else if (lex_byte == CH_SLASH) begin
                    mode_next = M_SLASH;
                end
                if (len_reg != '0) begin
                    em_req = 1'b1;
                end else begin
                    clr_req = 1'b1;
                end
            end else if (is_punct(lex_byte)) begin
                if (len_reg != '0) begin
                    em_req  = 1'b1;
                    em_cont = S_LEX2;
                end else begin
                    push_req  = 1'b1;
                    push_item = make_item(lex_byte, 1'b1, 1'b1, TYPE_PLAIN, FAULT_NONE);
                end
            end else if (lex_byte == CH_HASH) begin
                idx_next   = '0;
                val_next   = '0;
                state_next = S_PRD;
            end else begin
                app_req = 1'b1;
                app_val = to_lower(lex_byte);
            end
        end

        if (app_req) begin
            if (len_reg < LW'(MAX_TOKEN_LEN)) begin
                ram_we      = 1'b1;
                ram_wr_data = app_val;
                len_next    = LW'(len_reg + LW'(1));
            end else begin
                ovf_next = 1'b1;
            end
        end

        if (clr_req) begin
            len_next = '0;
            ovf_next = 1'b0;
        end

        if (em_req) begin
            em_type_next  = em_type;
            em_fault_next = ((em_fault == FAULT_NONE) && ovf_reg) ? FAULT_TRUNC : em_fault;
            idx_next      = '0;
            cont_next     = em_cont;
            state_next    = S_ERD;
        end

        fin_go = fin_req && push_ok;
        if (fin_go) begin
            state_next = S_IDLE;
        end
    end

    // Result path: the holding stage keeps the newest result until it is known
    // whether another result of the same item follows.
    always_comb begin
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (push_req) begin
            if (pend_valid_reg) begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = push_item;
            pend_valid_next = 1'b1;
        end
        if (fin_go && pend_valid_reg) begin
            out_next          = pend_reg;
            out_next.run_last = 1'b1;
            out_valid_next    = 1'b1;
            pend_valid_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_PLAIN;
            qk_reg         <= QK_DOUBLE;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            qk_reg         <= qk_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        end_reg      <= end_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        em_type_reg  <= em_type_next;
        em_fault_reg <= em_fault_next;
        cont_reg     <= cont_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

// ----- rtl/core/stt_checker.sv -----
// Port-level checker of the SQL text tokenizer, bound to its top level.
// Depends on stt_pkg and sql_text_tokenizer_unit_macros.svh.
`include "sql_text_tokenizer_unit_macros.svh"

module stt_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input stt_pkg::stt_in_t  s_item,
    input logic              m_valid,
    input logic              m_ready,
    input stt_pkg::stt_out_t m_item
);
    import stt_pkg::*;

    // A stalled result holds still.
    `STT_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_item), "result item changed while stalled")

    // An accepted item is never followed at once by another accepted item.
    `STT_ASSERT(a_one_item, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input accepted twice in a row")

    // A result without a character either closes a token or reports a bad length.
    `STT_ASSERT(a_report_form, aclk, aresetn, m_valid && !m_item.char_valid && !m_item.token_last |-> m_item.fault == FAULT_BAD_LEN && m_item.token_type == TYPE_PLAIN, "malformed report item")

    `STT_ASSERT(a_empty_char, aclk, aresetn, m_valid && !m_item.char_valid |-> m_item.token_char == 8'd0, "character present on a closing item")

    `STT_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind sql_text_tokenizer_unit stt_checker u_stt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for the SQL text tokenizer (sql_text_tokenizer_unit).
// A directed table and random SQL fragments are fed through a lexer model kept here.
// Depends on stt_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module testbench;
    import stt_pkg::*;

    localparam int          TOKEN_CAP   = DEF_MAX_TOKEN_LEN;
    localparam int          MAX_RUN     = 33;
    localparam logic [63:0] BLOB_LIMIT  = 64'hFFFF_FFFF;
    localparam int          RANDOM_ITEMS = 120;
    localparam int          HOLD_AFTER  = 60;
    localparam int          HOLD_CYCLES = 300;
    localparam int          IDLE_LIMIT  = 5000;
    localparam int          TAIL_CYCLES = 100;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    typedef enum logic [3:0] {
        LX_PLAIN, LX_QUOTE, LX_QESC, LX_QCLOSE, LX_DASH, LX_SLASH,
        LX_LINE, LX_BLOCK, LX_BSTAR, LX_BLOB, LX_BHASH
    } lex_state_e;

    typedef struct {
        stt_in_t  item;
        bit       typed;
        stt_out_t want;
    } stim_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    stt_in_t  s_item  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    stt_out_t m_item;

    stim_t    plan[$];
    stt_out_t token_items_due[$];
    stt_out_t step_out[$];
    int       accept_idx   = 0;
    int       random_items = 0;
    int       error_count  = 0;
    int       idle_cycles  = 0;
    bit       draining     = 1'b0;

    // Lexer state as the block should hold it.
    lex_state_e lx_mode = LX_PLAIN;
    logic [7:0] q_delim = CH_DQUOTE;
    logic [1:0] q_type  = TYPE_TEXT;
    logic [7:0] tok_buf [TOKEN_CAP];
    int         tok_len = 0;
    bit         tok_overflow = 1'b0;
    logic [63:0] blob_left = '0;

    sql_text_tokenizer_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------- lexer model

    function automatic void add_result(logic [7:0] ch, logic valid, logic last,
                                       logic [1:0] ttype, logic [1:0] flt);
        stt_out_t r;
        if (step_out.size() >= MAX_RUN) return;
        r.token_char = ch;
        r.char_valid = valid;
        r.token_last = last;
        r.token_type = ttype;
        r.fault      = flt;
        r.run_last   = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void keep_char(logic [7:0] b);
        if (tok_len < TOKEN_CAP) begin
            tok_buf[tok_len] = b;
            tok_len++;
        end else begin
            tok_overflow = 1'b1;
        end
    endfunction

    function automatic void release_token(logic [1:0] ttype, logic [1:0] flt);
        logic [1:0] f;
        f = flt;
        if (f == FAULT_NONE && tok_overflow) f = FAULT_TRUNC;
        if (tok_len == 0) add_result(8'h00, 1'b0, 1'b1, ttype, f);
        for (int i = 0; i < tok_len; i++)
            add_result(tok_buf[i], 1'b1, i + 1 == tok_len, ttype, f);
        tok_len = 0;
        tok_overflow = 1'b0;
    endfunction

    function automatic void flush_word();
        if (tok_len != 0) begin
            release_token(TYPE_PLAIN, FAULT_NONE);
        end else begin
            tok_overflow = 1'b0;
        end
    endfunction

    // The pending token is a blob length: decimal, not truncated, within range.
    function automatic void open_blob();
        logic [63:0] val;
        logic [7:0]  c;
        bit          ok;
        val = '0;
        ok = (tok_len != 0) && !tok_overflow;
        for (int i = 0; ok && i < tok_len; i++) begin
            c = tok_buf[i];
            if (c < CH_ZERO || c > CH_NINE) ok = 1'b0;
            else if (val > (BLOB_LIMIT - (c - CH_ZERO)) / 10) ok = 1'b0;
            else val = val * 10 + (c - CH_ZERO);
        end
        tok_len = 0;
        tok_overflow = 1'b0;
        if (!ok) begin
            add_result(8'h00, 1'b0, 1'b0, TYPE_PLAIN, FAULT_BAD_LEN);
            lx_mode = LX_PLAIN;
        end else begin
            blob_left = val;
            if (val != 0) lx_mode = LX_BLOB;
            else lx_mode = LX_BHASH;
        end
    endfunction

    function automatic void scan_plain(logic [7:0] b);
        lx_mode = LX_PLAIN;
        if (b == CH_DQUOTE || b == CH_SQUOTE || b == CH_TICK) begin
            q_delim = b;
            if (b == CH_DQUOTE) q_type = TYPE_TEXT;
            else if (b == CH_TICK) q_type = TYPE_NAME;
            else q_type = TYPE_PLAIN;
            lx_mode = LX_QUOTE;
            return;
        end
        case (b)
            CH_SPACE, CH_TAB, CH_NL, CH_CR: flush_word();
            CH_DASH: begin
                flush_word();
                lx_mode = LX_DASH;
            end
            CH_SLASH: begin
                flush_word();
                lx_mode = LX_SLASH;
            end
            CH_SEMI, CH_EQUAL, CH_PLUS, CH_STAR, CH_BANG, CH_COMMA, CH_LPAREN, CH_RPAREN: begin
                flush_word();
                add_result(b, 1'b1, 1'b1, TYPE_PLAIN, FAULT_NONE);
            end
            CH_HASH: open_blob();
            default: begin
                if (b >= CH_UPPER_A && b <= CH_UPPER_Z) keep_char(b + 8'd32);
                else keep_char(b);
            end
        endcase
    endfunction

    // Works out every token item that one accepted text item causes.
    function automatic void lex_byte(stt_in_t it);
        logic [7:0] b;
        stt_out_t   tail;
        b = it.text_byte;
        step_out.delete();
        case (lx_mode)
            LX_QUOTE: begin
                if (b == CH_BSL) lx_mode = LX_QESC;
                else if (b == q_delim) lx_mode = LX_QCLOSE;
                else keep_char(b);
            end
            LX_QESC: begin
                keep_char(b);
                lx_mode = LX_QUOTE;
            end
            LX_QCLOSE: begin
                if (b == q_delim) begin
                    keep_char(b);
                    lx_mode = LX_QUOTE;
                end else begin
                    release_token(q_type, FAULT_NONE);
                    scan_plain(b);
                end
            end
            LX_DASH: begin
                if (b == CH_DASH) begin
                    lx_mode = LX_LINE;
                end else begin
                    add_result(CH_DASH, 1'b1, 1'b1, TYPE_PLAIN, FAULT_NONE);
                    scan_plain(b);
                end
            end
            LX_SLASH: begin
                if (b == CH_STAR) begin
                    lx_mode = LX_BLOCK;
                end else begin
                    add_result(CH_SLASH, 1'b1, 1'b1, TYPE_PLAIN, FAULT_NONE);
                    scan_plain(b);
                end
            end
            LX_LINE: if (b == CH_NL) lx_mode = LX_PLAIN;
            LX_BLOCK: if (b == CH_STAR) lx_mode = LX_BSTAR;
            LX_BSTAR: begin
                if (b == CH_SLASH) lx_mode = LX_PLAIN;
                else if (b != CH_STAR) lx_mode = LX_BLOCK;
            end
            LX_BLOB: begin
                keep_char(b);
                blob_left = (blob_left - 1) & BLOB_LIMIT;
                if (blob_left == 0) lx_mode = LX_BHASH;
            end
            LX_BHASH: begin
                if (b == CH_HASH) begin
                    release_token(TYPE_BLOB, FAULT_NONE);
                    lx_mode = LX_PLAIN;
                end else begin
                    release_token(TYPE_BLOB, FAULT_NO_HASH);
                    scan_plain(b);
                end
            end
            default: scan_plain(b);
        endcase

        if (it.end_of_text) begin
            case (lx_mode)
                LX_QCLOSE:         release_token(q_type, FAULT_NONE);
                LX_QUOTE, LX_QESC: flush_word();
                LX_DASH:  add_result(CH_DASH, 1'b1, 1'b1, TYPE_PLAIN, FAULT_NONE);
                LX_SLASH: add_result(CH_SLASH, 1'b1, 1'b1, TYPE_PLAIN, FAULT_NONE);
                LX_BLOB, LX_BHASH: release_token(TYPE_BLOB, FAULT_NO_HASH);
                LX_PLAIN:          flush_word();
                default: ;
            endcase
            lx_mode = LX_PLAIN;
            tok_len = 0;
            tok_overflow = 1'b0;
            blob_left = '0;
        end

        if (step_out.size() > 0) begin
            tail = step_out.pop_back();
            tail.run_last = 1'b1;
            step_out.push_back(tail);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void feed(logic [7:0] b, bit counts);
        stim_t s;
        s.item.text_byte   = b;
        s.item.end_of_text = 1'b0;
        s.typed = 1'b0;
        s.want  = '0;
        plan.push_back(s);
        if (counts) random_items++;
    endfunction

    function automatic void feed_text(string txt);
        for (int i = 0; i < txt.len(); i++) feed(txt[i], 1'b1);
    endfunction

    function automatic void mark_end();
        stim_t s;
        s = plan.pop_back();
        s.item.end_of_text = 1'b1;
        plan.push_back(s);
    endfunction

    function automatic void directed(logic [7:0] b, logic eot, bit typed, stt_out_t want);
        stim_t s;
        s.item.text_byte   = b;
        s.item.end_of_text = eot;
        s.typed = typed;
        s.want  = want;
        plan.push_back(s);
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c = 8'h61 + 8'($urandom_range(0, 25));
            4, 5:       c = CH_UPPER_A + 8'($urandom_range(0, 25));
            6, 7:       c = CH_ZERO + 8'($urandom_range(0, 9));
            8:          c = 8'h5F;
            default:    c = 8'($urandom_range(128, 255));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_space();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = CH_SPACE;
            1:       c = CH_TAB;
            2:       c = CH_NL;
            default: c = CH_CR;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_punct();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = CH_SEMI;
            1:       c = CH_EQUAL;
            2:       c = CH_PLUS;
            3:       c = CH_STAR;
            4:       c = CH_BANG;
            5:       c = CH_COMMA;
            6:       c = CH_LPAREN;
            default: c = CH_RPAREN;
        endcase
        return c;
    endfunction

    // One random SQL fragment; comment bodies are fed but not counted.
    function automatic void add_fragment();
        int         n;
        logic [7:0] delim;
        case ($urandom_range(0, 15))
            0, 1, 2, 3: begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 8);
                repeat (n) feed(word_char(), 1'b1);
            end
            4: feed(pick_space(), 1'b1);
            5: feed(pick_punct(), 1'b1);
            6, 7: begin
                case ($urandom_range(0, 2))
                    0:       delim = CH_DQUOTE;
                    1:       delim = CH_SQUOTE;
                    default: delim = CH_TICK;
                endcase
                feed(delim, 1'b1);
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 9))
                        6: begin
                            feed(CH_BSL, 1'b1);
                            feed(8'($urandom_range(0, 255)), 1'b1);
                        end
                        7: begin
                            feed(delim, 1'b1);
                            feed(delim, 1'b1);
                        end
                        8:       feed(CH_SPACE, 1'b1);
                        9:       feed(($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE, 1'b1);
                        default: feed(word_char(), 1'b1);
                    endcase
                end
                // Now and then the quote is left open.
                if ($urandom_range(0, 7) != 0) feed(delim, 1'b1);
            end
            8: begin
                feed(CH_DASH, 1'b1);
                feed(CH_DASH, 1'b1);
                repeat ($urandom_range(0, 5)) feed(word_char(), 1'b0);
                feed(CH_NL, 1'b1);
            end
            9: begin
                feed(CH_SLASH, 1'b1);
                feed(CH_STAR, 1'b1);
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 3))
                        0:       feed(CH_STAR, 1'b0);
                        1:       feed(CH_SLASH, 1'b0);
                        2:       feed(CH_NL, 1'b0);
                        default: feed(word_char(), 1'b0);
                    endcase
                end
                feed(CH_STAR, 1'b1);
                feed(CH_SLASH, 1'b1);
            end
            10, 11: begin
                case ($urandom_range(0, 15))
                    12:           n = 35;
                    13, 14, 15:   n = $urandom_range(5, 9);
                    default:      n = $urandom_range(0, 4);
                endcase
                feed_text($sformatf("%0d", n));
                feed(CH_HASH, 1'b1);
                repeat (n) feed(8'($urandom_range(0, 255)), 1'b1);
                if ($urandom_range(0, 7) != 0) feed(CH_HASH, 1'b1);
            end
            12: begin
                case ($urandom_range(0, 4))
                    0: begin
                        repeat ($urandom_range(1, 3)) feed(word_char(), 1'b1);
                        feed(CH_HASH, 1'b1);
                    end
                    1: feed(CH_HASH, 1'b1);
                    2: feed_text("4294967296#");
                    3: begin
                        // Largest legal length, cut short by the end of the text.
                        feed_text("4294967295#");
                        feed(8'($urandom_range(0, 255)), 1'b1);
                        mark_end();
                    end
                    default: feed_text("99999999999999999999#");
                endcase
            end
            13: begin
                feed(($urandom_range(0, 1) != 0) ? CH_DASH : CH_SLASH, 1'b1);
                if ($urandom_range(0, 1) != 0) mark_end();
                else feed(word_char(), 1'b1);
            end
            14: repeat ($urandom_range(1, 3)) feed(8'($urandom_range(0, 255)), 1'b1);
            default: begin
                feed(8'($urandom_range(0, 255)), 1'b1);
                mark_end();
            end
        endcase
        if ($urandom_range(0, 9) == 0) mark_end();
        else if ($urandom_range(0, 3) != 0) feed(pick_space(), 1'b1);
    endfunction

    function automatic void build_plan();
        // Opening rows: extremes, bad length, empty quote and the end of text after '-'.
        directed(CH_SEMI, 1'b0, 1'b1, {CH_SEMI, 1'b1, 1'b1, TYPE_PLAIN, FAULT_NONE, 1'b1});
        directed(8'hFF, 1'b0, 1'b0, '0);
        directed(CH_HASH, 1'b0, 1'b1, {8'h00, 1'b0, 1'b0, TYPE_PLAIN, FAULT_BAD_LEN, 1'b1});
        directed(8'h00, 1'b1, 1'b1, {8'h00, 1'b1, 1'b1, TYPE_PLAIN, FAULT_NONE, 1'b1});
        directed(CH_DASH, 1'b1, 1'b1, {CH_DASH, 1'b1, 1'b1, TYPE_PLAIN, FAULT_NONE, 1'b1});
        directed(CH_DQUOTE, 1'b0, 1'b0, '0);
        directed(CH_DQUOTE, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, TYPE_TEXT, FAULT_NONE, 1'b1});
        // Quote after text, an escape and a doubled delimiter, then a block comment.
        directed("A", 1'b0, 1'b0, '0);
        directed(CH_TICK, 1'b0, 1'b0, '0);
        directed(CH_BSL, 1'b0, 1'b0, '0);
        directed(CH_TICK, 1'b0, 1'b0, '0);
        directed(CH_TICK, 1'b0, 1'b0, '0);
        directed(CH_TICK, 1'b0, 1'b0, '0);
        directed(CH_TICK, 1'b0, 1'b0, '0);
        directed(CH_SLASH, 1'b0, 1'b0, '0);
        directed(CH_STAR, 1'b0, 1'b0, '0);
        directed(CH_STAR, 1'b0, 1'b0, '0);
        directed(CH_SLASH, 1'b0, 1'b0, '0);
        // A two-byte blob whose closing hash is missing, then a line comment.
        directed("2", 1'b0, 1'b0, '0);
        directed(CH_HASH, 1'b0, 1'b0, '0);
        directed("x", 1'b0, 1'b0, '0);
        directed("Y", 1'b0, 1'b0, '0);
        directed(CH_DASH, 1'b0, 1'b0, '0);
        directed(CH_DASH, 1'b0, 1'b0, '0);
        directed(CH_NL, 1'b0, 1'b0, '0);
        // The text ends inside an open single quote.
        directed(CH_SQUOTE, 1'b0, 1'b0, '0);
        directed("Q", 1'b1, 1'b1, {"Q", 1'b1, 1'b1, TYPE_PLAIN, FAULT_NONE, 1'b1});
        while (random_items < RANDOM_ITEMS) add_fragment();
    endfunction

    // ---------------------------------------------------------------- sender

    initial begin : sender
        int burst_left;
        int gap;
        build_plan();
        burst_left = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int idx = 0; idx < plan.size(); idx++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
            s_valid <= 1'b1;
            s_item  <= plan[idx].item;
            do @(posedge aclk); while (!s_ready);
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (token_items_due.size() != 0) @(posedge aclk);
        draining = 1'b1;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && token_items_due.size() == 0) begin
            $display("PASS sql_text_tokenizer_unit");
        end else begin
            $display("FAIL sql_text_tokenizer_unit");
        end
        $finish;
    end

    // ---------------------------------------------------------------- receiver

    initial begin : receiver
        int  style;
        int  left;
        bit  held;
        style = 0;
        left = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (draining) begin
                m_ready <= 1'b1;
            end else if (!held && accept_idx >= HOLD_AFTER) begin
                // Long hold-off while the sender keeps offering, so the block backs up.
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                if (left == 0) begin
                    style = $urandom_range(0, 3);
                    left = $urandom_range(16, 80);
                end
                left--;
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) != 0);
                    2:       m_ready <= (left % 4 != 0);
                    default: m_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- checking

    always @(posedge aclk) begin : text_accept
        if (aresetn && s_valid && s_ready) begin
            lex_byte(s_item);
            if (plan[accept_idx].typed) begin
                token_items_due.push_back(plan[accept_idx].want);
            end else begin
                foreach (step_out[k]) token_items_due.push_back(step_out[k]);
            end
            accept_idx++;
        end
    end

    always @(posedge aclk) begin : token_check
        stt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (token_items_due.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected item: char=%h valid=%b last=%b type=%0d fault=%0d run=%b",
                             m_item.token_char, m_item.char_valid, m_item.token_last,
                             m_item.token_type, m_item.fault, m_item.run_last);
            end else begin
                want = token_items_due.pop_front();
                if (m_item.token_char !== want.token_char ||
                    m_item.char_valid !== want.char_valid ||
                    m_item.token_last !== want.token_last ||
                    m_item.token_type !== want.token_type ||
                    m_item.fault      !== want.fault ||
                    m_item.run_last   !== want.run_last) begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"mismatch: got char=%h valid=%b last=%b type=%0d fault=%0d ",
                                  "run=%b, expected char=%h valid=%b last=%b type=%0d ",
                                  "fault=%0d run=%b"},
                                 m_item.token_char, m_item.char_valid, m_item.token_last,
                                 m_item.token_type, m_item.fault, m_item.run_last,
                                 want.token_char, want.char_valid, want.token_last,
                                 want.token_type, want.fault, want.run_last);
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL sql_text_tokenizer_unit");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/stt_pkg.sv
rtl/core/stt_ram.sv
rtl/core/sql_text_tokenizer_unit.sv
rtl/core/stt_checker.sv
sim/testbench.sv
